/* design/ritpj_pkg.sv */
`timescale 1ns / 1ps

package ritpj_pkg;

	// Sample and field widths.
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned ROW_SIDE_N   = 4;
	localparam int unsigned ROW_N        = 2 * ROW_SIDE_N + 1;
	localparam int unsigned COL_N        = 5;
	localparam int unsigned CFG_INDEX_W  = 3;
	localparam int unsigned CFG_DATA_W   = 16;

	// Threshold arithmetic constants.
	localparam logic [SAMPLE_W-1:0] INVALID_DIFF = 16'hFFFF;
	localparam int unsigned ADJ_SHIFT  = 12;
	// A ratio shifted left by 4 and a product shifted right by 7 net a right shift by 3.
	localparam int unsigned NEAR_SHIFT = 3;
	localparam logic [4:0]  NEAR_MIN   = 5'd2;
	localparam logic [4:0]  NEAR_MAX   = 5'd20;
	localparam logic [3:0]  VER_MIN    = 4'd3;
	localparam logic [2:0]  ZERO_MAX   = 3'd3;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ADJ_RATIO_Q12        = 3'd0,
		REG_DIFF_UPPER_LIMIT     = 3'd1,
		REG_NEAR_COUNT_LIMIT_COL = 3'd2,
		REG_NEAR_COUNT_LIMIT_ROW = 3'd3,
		REG_RANGE_CUTOFF         = 3'd4,
		REG_NEAR_RATIO           = 3'd5,
		REG_SLOPE_LIMIT          = 3'd6
	} cfg_index_t;

	// Current register contents as seen by the datapath.
	typedef struct packed {
		logic [15:0] adj_ratio_q12;
		logic [15:0] diff_upper_limit;
		logic [2:0]  near_count_limit_col;
		logic [3:0]  near_count_limit_row;
		logic [15:0] range_cutoff;
		logic [11:0] near_ratio;
		logic [14:0] slope_limit;
	} cfg_t;

	// Absolute difference of two samples.
	function automatic logic [SAMPLE_W-1:0] abs_diff(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Distance to the center; an invalid sample reads as the largest difference.
	function automatic logic [SAMPLE_W-1:0] center_diff(
		input logic [SAMPLE_W-1:0] x,
		input logic [SAMPLE_W-1:0] c
	);
		return (x == '0) ? INVALID_DIFF : abs_diff(x, c);
	endfunction

endpackage

/* design/ritpj_cfg_regs.sv */
`timescale 1ns / 1ps

module ritpj_cfg_regs
	import ritpj_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Decode a write beat; an index beyond the list leaves every register alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_ADJ_RATIO_Q12:        cfg_q.adj_ratio_q12        <= wr_data;
				REG_DIFF_UPPER_LIMIT:     cfg_q.diff_upper_limit     <= wr_data;
				REG_NEAR_COUNT_LIMIT_COL: cfg_q.near_count_limit_col <= wr_data[2:0];
				REG_NEAR_COUNT_LIMIT_ROW: cfg_q.near_count_limit_row <= wr_data[3:0];
				REG_RANGE_CUTOFF:         cfg_q.range_cutoff         <= wr_data;
				REG_NEAR_RATIO:           cfg_q.near_ratio           <= wr_data[11:0];
				REG_SLOPE_LIMIT:          cfg_q.slope_limit          <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/range_image_trail_point_judge_unit.sv */
`timescale 1ns / 1ps

// Trail point judge for one range-image pixel per beat.
// Input channel: drive the center distance, the five column samples and the eight
// row samples around the center together with start; a beat is taken at every
// rising edge where start is high and busy is low. busy stays low, so a new pixel
// may be offered in every cycle.
// Result channel: trail_mark appears with done high for exactly one cycle once its
// beat has passed stages s1, s2 and s3, in input order. The receiver cannot hold
// a result off, and none is needed: the three-stage pipeline never stalls.
// Throughput is one pixel per cycle; the stages are multiply, then threshold and
// mean, then count and combine.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready is
// always high. Write registers only while no pixel is in flight.
// Reset clears the configuration registers and the valid and mark flags to zero
// and empties the pipeline; no result is produced for a beat caught in it at reset.
module range_image_trail_point_judge_unit
	import ritpj_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [15:0]            col_far_above,
	input  logic [15:0]            col_near_above,
	input  logic [15:0]            center_distance,
	input  logic [15:0]            col_near_below,
	input  logic [15:0]            col_far_below,
	input  logic [63:0]            row_left_four,
	input  logic [63:0]            row_right_four,
	output logic                   done,
	output logic                   trail_mark,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg;
	logic accept;

	// Register file.
	ritpj_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	// ---------------- Stage 1: products, differences, center distances ----------
	logic [SAMPLE_W-1:0] col [COL_N];
	logic [SAMPLE_W-1:0] row [ROW_N];
	logic [SAMPLE_W-1:0] adjd_c [COL_N-1];
	logic [16:0]         d2_c [COL_N-2];
	logic [27:0]         p_near_c;
	logic [31:0]         p_adj_c;

	always_comb begin
		logic signed [16:0] d [COL_N-1];
		logic signed [17:0] t;
		col[0] = col_far_above;
		col[1] = col_near_above;
		col[2] = center_distance;
		col[3] = col_near_below;
		col[4] = col_far_below;
		for (int i = 0; i < ROW_SIDE_N; i++) begin
			row[i]              = row_left_four[i*SAMPLE_W +: SAMPLE_W];
			row[ROW_SIDE_N+1+i] = row_right_four[i*SAMPLE_W +: SAMPLE_W];
		end
		row[ROW_SIDE_N] = center_distance;
		// Adjacent steps along the column, plain and signed.
		for (int i = 0; i < COL_N - 1; i++) begin
			adjd_c[i] = abs_diff(col[i+1], col[i]);
			d[i] = $signed({1'b0, col[i+1]}) - $signed({1'b0, col[i]});
		end
		// Second differences.
		for (int i = 0; i < COL_N - 2; i++) begin
			t = 18'(d[i+1]) - 18'(d[i]);
			d2_c[i] = t[17] ? 17'(-t) : t[16:0];
		end
		p_near_c = 28'(center_distance) * 28'(cfg.near_ratio);
		p_adj_c  = 32'(center_distance) * 32'(cfg.adj_ratio_q12);
	end

	logic                vld_s1;
	logic                pt_ok_s1;
	logic [27:0]         p_near_s1;
	logic [31:0]         p_adj_s1;
	logic [SAMPLE_W-1:0] adjd_s1 [COL_N-1];
	logic [16:0]         d2_s1 [COL_N-2];
	logic [SAMPLE_W-1:0] dcc_s1 [COL_N];
	logic [COL_N-1:0]    colz_s1;
	logic [SAMPLE_W-1:0] dcr_s1 [ROW_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pt_ok_s1  <= (center_distance != '0) && (center_distance < cfg.range_cutoff);
		p_near_s1 <= p_near_c;
		p_adj_s1  <= p_adj_c;
		adjd_s1   <= adjd_c;
		d2_s1     <= d2_c;
		for (int i = 0; i < COL_N; i++) begin
			dcc_s1[i]  <= center_diff(col[i], center_distance);
			colz_s1[i] <= (col[i] == '0);
		end
		for (int i = 0; i < ROW_N; i++) begin
			dcr_s1[i] <= center_diff(row[i], center_distance);
		end
	end

	// ---------------- Stage 2: thresholds, weighted mean, wall test ------------
	logic [4:0]  nearth_c;
	logic [19:0] adj_c;
	logic [16:0] mean_c;
	logic        zeros_ok_c;
	logic        wall_or_ver_c;

	always_comb begin
		logic [24:0] near_raw;
		logic [19:0] adj_raw;
		logic [18:0] wsum;
		logic [2:0]  zeros;
		logic [18:0] d2_sum;
		logic [15:0] slope2;
		logic [3:0]  ver_cnt;
		logic        wall;
		near_raw = p_near_s1[27:NEAR_SHIFT];
		if (near_raw < 25'(NEAR_MIN)) begin
			nearth_c = NEAR_MIN;
		end else if (near_raw > 25'(NEAR_MAX)) begin
			nearth_c = NEAR_MAX;
		end else begin
			nearth_c = near_raw[4:0];
		end
		adj_raw = p_adj_s1[31:ADJ_SHIFT];
		adj_c   = (adj_raw == '0) ? 20'd1 : adj_raw;
		// Weights 1,2,0,2,1; an invalid sample weighs nothing.
		wsum = (colz_s1[0] ? 19'd0 : 19'(dcc_s1[0]))
			+ (colz_s1[1] ? 19'd0 : {2'b0, dcc_s1[1], 1'b0})
			+ (colz_s1[3] ? 19'd0 : {2'b0, dcc_s1[3], 1'b0})
			+ (colz_s1[4] ? 19'd0 : 19'(dcc_s1[4]));
		mean_c = wsum[18:2];
		zeros = 3'(colz_s1[0]) + 3'(colz_s1[1]) + 3'(colz_s1[2])
			+ 3'(colz_s1[3]) + 3'(colz_s1[4]);
		zeros_ok_c = (zeros <= ZERO_MAX);
		d2_sum = 19'(d2_s1[0]) + 19'(d2_s1[1]) + 19'(d2_s1[2]);
		wall = (d2_sum > 19'(cfg.slope_limit)) && (d2_s1[0] > 17'(cfg.slope_limit));
		// Row samples close to the center under twice the slope limit.
		slope2  = {cfg.slope_limit, 1'b0};
		ver_cnt = '0;
		for (int i = 0; i < ROW_N; i++) begin
			ver_cnt = ver_cnt + 4'(dcr_s1[i] < slope2);
		end
		wall_or_ver_c = wall || (ver_cnt < VER_MIN);
	end

	logic                vld_s2;
	logic                pt_ok_s2;
	logic [4:0]          nearth_s2;
	logic [19:0]         adj_s2;
	logic [16:0]         mean_s2;
	logic                zeros_ok_s2;
	logic                wall_or_ver_s2;
	logic [SAMPLE_W-1:0] dc1_s2;
	logic [SAMPLE_W-1:0] dc3_s2;
	logic [SAMPLE_W-1:0] adjd_s2 [COL_N-1];
	logic [SAMPLE_W-1:0] dcr_s2 [ROW_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_ok_s2       <= pt_ok_s1;
		nearth_s2      <= nearth_c;
		adj_s2         <= adj_c;
		mean_s2        <= mean_c;
		zeros_ok_s2    <= zeros_ok_c;
		wall_or_ver_s2 <= wall_or_ver_c;
		dc1_s2         <= dcc_s1[1];
		dc3_s2         <= dcc_s1[3];
		adjd_s2        <= adjd_s1;
		dcr_s2         <= dcr_s1;
	end

	// ---------------- Stage 3: neighbor counts and the final decision ----------
	logic mark_c;

	always_comb begin
		logic [2:0] near_h;
		logic [3:0] near_v;
		logic [2:0] big_steps;
		logic       con1;
		logic       con2;
		logic       hor;
		near_h    = '0;
		big_steps = '0;
		for (int i = 0; i < COL_N - 1; i++) begin
			near_h    = near_h + 3'(adjd_s2[i] < 16'(nearth_s2));
			big_steps = big_steps + 3'(20'(adjd_s2[i]) > adj_s2);
		end
		near_v = '0;
		for (int i = 0; i < ROW_N; i++) begin
			near_v = near_v + 4'(dcr_s2[i] < 16'(nearth_s2));
		end
		con1 = ((20'(dc1_s2) > adj_s2) && (dc1_s2 < cfg.diff_upper_limit)
			&& (20'(dc3_s2) > adj_s2) && (dc3_s2 < cfg.diff_upper_limit))
			|| (big_steps == 3'(COL_N - 1));
		con2 = (20'(mean_s2) > adj_s2) && (mean_s2 < 17'(cfg.diff_upper_limit));
		hor  = zeros_ok_s2 && (con1 || con2);
		mark_c = pt_ok_s2 && (near_h < cfg.near_count_limit_col) && hor
			&& (near_v < cfg.near_count_limit_row) && wall_or_ver_s2;
	end

	logic vld_s3;
	logic mark_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			mark_s3 <= 1'b0;
		end else begin
			vld_s3  <= vld_s2;
			mark_s3 <= vld_s2 && mark_c;
		end
	end

	assign done       = vld_s3;
	assign trail_mark = mark_s3;

	// ---------------- Checks ----------------
	// Every accepted beat yields a result at the end of the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> ##3 done)
		else $error("accepted beat produced no result");

	// No result appears without a matching beat taken at the pipeline input.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without an accepted beat");

	// The mark is only raised together with the result strobe.
	assert property (@(posedge clk) disable iff (!arst_n) trail_mark |-> done)
		else $error("trail mark outside a result beat");

endmodule
